@@ hw/rtl/bmalloc_pkg.sv @@
// Package for the bitmap first-free allocator: sizes, operation and status
// codes, the memory request struct and the lowest-clear-bit finder.
// No dependencies.
package bmalloc_pkg;

	// Bitmap geometry (WORD_BITS is a power of two)
	localparam int unsigned NUM_ENTRIES = 128;
	localparam int unsigned WORD_BITS   = 8;
	localparam int unsigned ALLOC_WORDS = (NUM_ENTRIES + WORD_BITS - 1) / WORD_BITS;
	localparam int unsigned BIT_W       = $clog2(WORD_BITS);
	localparam int unsigned ADDR_W      = (ALLOC_WORDS > 1) ? $clog2(ALLOC_WORDS) : 1;
	localparam int unsigned ENTRY_W     = ADDR_W + BIT_W;

	// Port field widths
	localparam int unsigned OP_W     = 2;
	localparam int unsigned INDEX_W  = 7;
	localparam int unsigned STATUS_W = 2;

	// Operation codes
	localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
	localparam logic [OP_W-1:0] OP_MARK    = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_WAS_FREE = 2'd2;

	localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(ALLOC_WORDS - 1);

	typedef logic [WORD_BITS-1:0] word_t;

	// Request from the control logic to the bitmap memory
	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		word_t             wr_data;
	} mem_req_t;

	// Lowest clear bit of a word
	typedef struct packed {
		logic             found;
		logic [BIT_W-1:0] pos;
	} zero_pos_t;

	function automatic zero_pos_t first_zero(input word_t word);
		zero_pos_t res;
		res.found = 1'b0;
		res.pos   = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!word[i]) begin
				res.found = 1'b1;
				res.pos   = BIT_W'(i);
			end
		end
		return res;
	endfunction

endpackage

@@ hw/rtl/bmalloc_mem.sv @@
// Bitmap memory of the allocator: one word array with a registered read port
// and a write port, plus per-word valid flags so reset reads as all free.
// Depends on bmalloc_pkg.
module bmalloc_mem (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bmalloc_pkg::mem_req_t req,
	output bmalloc_pkg::word_t    rd_data
);

	bmalloc_pkg::word_t mem_q [bmalloc_pkg::ALLOC_WORDS];
	logic [bmalloc_pkg::ALLOC_WORDS-1:0] vld_q;
	bmalloc_pkg::word_t rd_data_q;

	// Word store
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
	end

	// Valid flags: a word never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (req.wr_en) begin
			vld_q[req.wr_addr] <= 1'b1;
		end
	end

	// Registered read, holds when no read is issued
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_q <= vld_q[req.rd_addr] ? mem_q[req.rd_addr] : '0;
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hw/rtl/bitmap_first_free_allocator.sv @@
// Top level of the bitmap first-free allocator: request handshake, scan
// sequencer, bitmap read-modify-write and result register.
// Depends on bmalloc_pkg and bmalloc_mem.
//
//  channel | handshake           | fields                 | carries
//  --------+---------------------+------------------------+--------
//  in      | in_valid/in_ready   | operation, entry_index | request
//  out     | out_valid/out_ready | status, granted_index  | result
//
// Release, mark and the unused code use the word read at acceptance and load the
// result once the result register is free. Allocate reads one bitmap word per
// cycle from word 0 to the first word with a clear bit, or to the last one if full.
// One transaction is in work at a time; the next is taken in the cycle after a result
// is loaded, even while that result waits. Reset clears the bitmap at once.
// A stalled output holds the sequencer until the result register frees.
module bitmap_first_free_allocator (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [bmalloc_pkg::OP_W-1:0]           operation,
	input  logic [bmalloc_pkg::INDEX_W-1:0]        entry_index,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [bmalloc_pkg::STATUS_W-1:0]       status,
	output logic [bmalloc_pkg::INDEX_W-1:0]        granted_index
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EVAL = 2'b10
	} state_t;

	state_t state_q, state_d;

	logic [bmalloc_pkg::OP_W-1:0]     op_q;
	logic [bmalloc_pkg::INDEX_W-1:0]  idx_q;
	logic [bmalloc_pkg::ADDR_W-1:0]   addr_q, addr_d;
	logic                             out_valid_q;
	logic [bmalloc_pkg::STATUS_W-1:0] status_q;
	logic [bmalloc_pkg::INDEX_W-1:0]  granted_q;

	bmalloc_pkg::mem_req_t  mem_req;
	bmalloc_pkg::word_t     rd_word;
	bmalloc_pkg::zero_pos_t zpos;

	logic [bmalloc_pkg::ENTRY_W-1:0]  in_entry, req_entry, cand_entry;
	logic                             req_in_range;
	bmalloc_pkg::word_t               bit_mask, cand_mask;
	logic                             accept, done, out_free, load_out;
	logic                             do_write;
	bmalloc_pkg::word_t               wr_word;
	logic [bmalloc_pkg::STATUS_W-1:0] res_status;
	logic [bmalloc_pkg::INDEX_W-1:0]  res_index;

	bmalloc_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_data (rd_word)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Entry decode of the incoming and the held index
	assign in_entry     = bmalloc_pkg::ENTRY_W'(entry_index);
	assign req_entry    = bmalloc_pkg::ENTRY_W'(idx_q);
	assign req_in_range = 32'(idx_q) < bmalloc_pkg::NUM_ENTRIES;
	assign bit_mask     = bmalloc_pkg::WORD_BITS'(1) << req_entry[bmalloc_pkg::BIT_W-1:0];

	// Lowest clear bit of the word just read
	assign zpos       = bmalloc_pkg::first_zero(rd_word);
	assign cand_entry = {addr_q, zpos.pos};
	assign cand_mask  = bmalloc_pkg::WORD_BITS'(1) << zpos.pos;

	// Evaluation of the current word
	always_comb begin
		done       = 1'b0;
		do_write   = 1'b0;
		wr_word    = rd_word;
		res_status = bmalloc_pkg::STAT_OK;
		res_index  = idx_q;
		addr_d     = addr_q;
		if (op_q == bmalloc_pkg::OP_ALLOC) begin
			if (zpos.found) begin
				done = 1'b1;
				if (32'(cand_entry) < bmalloc_pkg::NUM_ENTRIES) begin
					do_write  = 1'b1;
					wr_word   = rd_word | cand_mask;
					res_index = bmalloc_pkg::INDEX_W'(cand_entry);
				end else begin
					res_status = bmalloc_pkg::STAT_FULL;
					res_index  = '0;
				end
			end else if (addr_q == bmalloc_pkg::LAST_WORD) begin
				done       = 1'b1;
				res_status = bmalloc_pkg::STAT_FULL;
				res_index  = '0;
			end else begin
				addr_d = addr_q + 1'b1;
			end
		end else begin
			done = 1'b1;
			if (req_in_range && op_q == bmalloc_pkg::OP_RELEASE) begin
				do_write = 1'b1;
				wr_word  = rd_word & ~bit_mask;
				if ((rd_word & bit_mask) == '0) begin
					res_status = bmalloc_pkg::STAT_WAS_FREE;
				end
			end else if (req_in_range && op_q == bmalloc_pkg::OP_MARK) begin
				do_write = 1'b1;
				wr_word  = rd_word | bit_mask;
			end
		end
	end

	assign load_out = (state_q == ST_EVAL) && done && out_free;

	// Memory requests: read on accept or scan step, write on completion
	always_comb begin
		mem_req         = '0;
		mem_req.wr_addr = addr_q;
		mem_req.wr_data = wr_word;
		mem_req.wr_en   = load_out && do_write;
		if (accept) begin
			mem_req.rd_en   = 1'b1;
			mem_req.rd_addr = (operation == bmalloc_pkg::OP_ALLOC) ? '0 :
				in_entry[bmalloc_pkg::ENTRY_W-1:bmalloc_pkg::BIT_W];
		end else if (state_q == ST_EVAL && !done) begin
			mem_req.rd_en   = 1'b1;
			mem_req.rd_addr = addr_d;
		end
	end

	// Sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Transaction hold registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= operation;
			idx_q  <= entry_index;
			addr_q <= (operation == bmalloc_pkg::OP_ALLOC) ? '0 :
				in_entry[bmalloc_pkg::ENTRY_W-1:bmalloc_pkg::BIT_W];
		end else if (state_q == ST_EVAL) begin
			addr_q <= addr_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q  <= res_status;
			granted_q <= res_index;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign granted_index = granted_q;

`ifndef SYNTHESIS
	// Bitmap is never read and written in the same cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.rd_en && mem_req.wr_en))
		else $error("bitmap read and write in one cycle");

	// A write-back always comes with a result
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.wr_en |=> out_valid)
		else $error("bitmap written without a result");

	// Full status always reports index zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == bmalloc_pkg::STAT_FULL) |-> (granted_index == '0))
		else $error("full status with non-zero index");

	// A finished transaction held by a busy output keeps its scan position
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL && done && !out_free) |=>
		(state_q == ST_EVAL && $stable(addr_q) && $stable(rd_word)))
		else $error("sequencer moved while output stalled");
`endif

endmodule

@@ bench/allocator_grant_checker.sv @@
// Checker for the bitmap first-free allocator: watches both channels, keeps a
// shadow bitmap, predicts each result and compares it with what comes out.
// Depends on bmalloc_pkg.
module allocator_grant_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic [bmalloc_pkg::OP_W-1:0]        operation,
	input  logic [bmalloc_pkg::INDEX_W-1:0]     entry_index,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic [bmalloc_pkg::STATUS_W-1:0]    status,
	input  logic [bmalloc_pkg::INDEX_W-1:0]     granted_index,
	output int unsigned                         failures,
	output int unsigned                         outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [bmalloc_pkg::STATUS_W-1:0] status;
		logic [bmalloc_pkg::INDEX_W-1:0]  index;
	} grant_result_t;

	// Shadow of the allocation bitmap, one word per scan step
	bmalloc_pkg::word_t bitmap_shadow [bmalloc_pkg::ALLOC_WORDS];
	grant_result_t      expected_grants [$];
	grant_result_t      oldest_grant;

	// Apply one request to the shadow bitmap and return the result it gives
	function automatic grant_result_t apply_request(input logic [bmalloc_pkg::OP_W-1:0] op,
			input logic [bmalloc_pkg::INDEX_W-1:0] idx);
		grant_result_t res;
		int unsigned   entry;
		int            w;
		int            b;
		logic          done;
		res.status = bmalloc_pkg::STAT_OK;
		res.index  = idx;
		case (op)
			bmalloc_pkg::OP_ALLOC: begin
				res.status = bmalloc_pkg::STAT_FULL;
				res.index  = '0;
				done       = 1'b0;
				// First word not all ones ends the scan, granted or not
				for (w = 0; w < bmalloc_pkg::ALLOC_WORDS && !done; w++) begin
					if (bitmap_shadow[w] != '1) begin
						for (b = 0; b < bmalloc_pkg::WORD_BITS && !done; b++) begin
							entry = w * bmalloc_pkg::WORD_BITS + b;
							if (entry >= bmalloc_pkg::NUM_ENTRIES) begin
								done = 1'b1;
							end else if (!bitmap_shadow[w][b]) begin
								bitmap_shadow[w][b] = 1'b1;
								res.status = bmalloc_pkg::STAT_OK;
								res.index  = bmalloc_pkg::INDEX_W'(entry);
								done       = 1'b1;
							end
						end
						done = 1'b1;
					end
				end
			end
			bmalloc_pkg::OP_RELEASE: begin
				if (idx < bmalloc_pkg::NUM_ENTRIES) begin
					w = idx / bmalloc_pkg::WORD_BITS;
					b = idx % bmalloc_pkg::WORD_BITS;
					if (!bitmap_shadow[w][b])
						res.status = bmalloc_pkg::STAT_WAS_FREE;
					bitmap_shadow[w][b] = 1'b0;
				end
			end
			bmalloc_pkg::OP_MARK: begin
				if (idx < bmalloc_pkg::NUM_ENTRIES) begin
					w = idx / bmalloc_pkg::WORD_BITS;
					b = idx % bmalloc_pkg::WORD_BITS;
					bitmap_shadow[w][b] = 1'b1;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// Compare results first, then predict the newly accepted transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < bmalloc_pkg::ALLOC_WORDS; w++)
				bitmap_shadow[w] = '0;
			expected_grants.delete();
			failures    = 0;
			outstanding = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_grants.size() == 0) begin
					if (failures < 10)
						$display("%0t: result with nothing expected: status %0d index %0d",
							$realtime, status, granted_index);
					failures++;
				end else begin
					oldest_grant = expected_grants.pop_front();
					if (status !== oldest_grant.status ||
							granted_index !== oldest_grant.index) begin
						if (failures < 10)
							$display("%0t: mismatch: status %0d/%0d index %0d/%0d (exp/got)",
								$realtime, oldest_grant.status, status,
								oldest_grant.index, granted_index);
						failures++;
					end
				end
			end
			if (in_valid && in_ready)
				expected_grants.push_back(apply_request(operation, entry_index));
			outstanding = expected_grants.size();
		end
	end

endmodule

@@ bench/bitmap_first_free_allocator_test.sv @@
// Top of the allocator testbench: clock, reset, request and ready stimulus,
// and the verdict. Depends on bmalloc_pkg, bitmap_first_free_allocator and
// allocator_grant_checker.
module bitmap_first_free_allocator_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [bmalloc_pkg::OP_W-1:0]    op_code_t;
	typedef logic [bmalloc_pkg::INDEX_W-1:0] index_t;

	localparam op_code_t    OP_UNUSED    = 2'd3;
	localparam int unsigned RANDOM_ITEMS = 1200;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned INDEX_MAX    = (1 << bmalloc_pkg::INDEX_W) - 1;

	logic                                clk;
	logic                                arst_n;
	logic                                in_valid;
	logic                                in_ready;
	op_code_t                            operation;
	index_t                              entry_index;
	logic                                out_valid;
	logic                                out_ready;
	logic [bmalloc_pkg::STATUS_W-1:0]    status;
	index_t                              granted_index;
	int unsigned                         failures;
	int unsigned                         outstanding;

	// Counts only transactions the block acts on
	int unsigned         accepted_items;
	logic                steady;
	int unsigned         episode;
	int unsigned         run_len;
	int unsigned         roll;

	bitmap_first_free_allocator i_dut (
		.clk,
		.arst_n,
		.in_valid,
		.in_ready,
		.operation,
		.entry_index,
		.out_valid,
		.out_ready,
		.status,
		.granted_index
	);

	allocator_grant_checker i_checker (
		.clk,
		.arst_n,
		.in_valid,
		.in_ready,
		.operation,
		.entry_index,
		.out_valid,
		.out_ready,
		.status,
		.granted_index,
		.failures,
		.outstanding
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side back-pressure, switched off during the steady stretch
	always @(negedge clk) begin
		out_ready <= arst_n && (steady || $urandom_range(99) >= 11);
	end

	// Present one request, with random idle cycles first, and hold until taken
	task automatic send_request(input op_code_t op, input index_t idx);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 11) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		operation   <= op;
		entry_index <= idx;
		do @(posedge clk); while (!in_ready);
		if (op != OP_UNUSED)
			accepted_items++;
		steady = (accepted_items >= 400 && accepted_items < 650);
	endtask

	// Hard stop if the block hangs
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		operation      = bmalloc_pkg::OP_ALLOC;
		entry_index    = '0;
		out_ready      = 1'b0;
		steady         = 1'b0;
		accepted_items = 0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: every operation, release of a free entry, mark of a taken
		// one, the unused code, and the index extremes
		send_request(bmalloc_pkg::OP_ALLOC, 7'h7f);
		send_request(bmalloc_pkg::OP_ALLOC, 7'h00);
		send_request(bmalloc_pkg::OP_MARK, 7'h02);
		send_request(bmalloc_pkg::OP_MARK, 7'h02);
		send_request(bmalloc_pkg::OP_ALLOC, 7'h2a);
		send_request(bmalloc_pkg::OP_RELEASE, 7'h00);
		send_request(bmalloc_pkg::OP_RELEASE, 7'h00);
		send_request(bmalloc_pkg::OP_ALLOC, 7'h55);
		send_request(bmalloc_pkg::OP_MARK, 7'h7f);
		send_request(bmalloc_pkg::OP_RELEASE, 7'h7f);
		send_request(bmalloc_pkg::OP_RELEASE, 7'h7f);
		send_request(OP_UNUSED, 7'h7f);
		send_request(OP_UNUSED, 7'h00);
		send_request(bmalloc_pkg::OP_MARK, 7'h40);
		send_request(bmalloc_pkg::OP_RELEASE, 7'h40);
		send_request(bmalloc_pkg::OP_RELEASE, 7'h3f);
		send_request(bmalloc_pkg::OP_MARK, 7'h08);
		send_request(bmalloc_pkg::OP_ALLOC, 7'h00);
		send_request(bmalloc_pkg::OP_RELEASE, 7'h01);
		send_request(bmalloc_pkg::OP_ALLOC, 7'h00);

		// Random episodes: fills to exhaustion, churn, drains that leave
		// deep holes, deep release and re-allocate pairs, and noise
		while (accepted_items < RANDOM_ITEMS) begin
			episode = $urandom_range(9);
			if (episode <= 2) begin
				run_len = $urandom_range(130, 150);
				repeat (run_len) begin
					roll = $urandom_range(99);
					if (roll < 88)
						send_request(bmalloc_pkg::OP_ALLOC,
							index_t'($urandom_range(INDEX_MAX)));
					else if (roll < 94)
						send_request(bmalloc_pkg::OP_MARK,
							index_t'($urandom_range(INDEX_MAX)));
					else
						send_request(bmalloc_pkg::OP_RELEASE,
							index_t'($urandom_range(INDEX_MAX)));
				end
			end else if (episode <= 5) begin
				run_len = $urandom_range(60, 120);
				repeat (run_len) begin
					roll = $urandom_range(99);
					if (roll < 45)
						send_request(bmalloc_pkg::OP_ALLOC,
							index_t'($urandom_range(INDEX_MAX)));
					else if (roll < 90)
						send_request(bmalloc_pkg::OP_RELEASE,
							index_t'($urandom_range($urandom_range(INDEX_MAX))));
					else if (roll < 95)
						send_request(bmalloc_pkg::OP_MARK,
							index_t'($urandom_range(INDEX_MAX)));
					else
						send_request(OP_UNUSED, index_t'($urandom_range(INDEX_MAX)));
				end
			end else if (episode <= 7) begin
				run_len = $urandom_range(60, 140);
				repeat (run_len) begin
					if ($urandom_range(99) < 85)
						send_request(bmalloc_pkg::OP_RELEASE,
							index_t'($urandom_range(INDEX_MAX)));
					else
						send_request(bmalloc_pkg::OP_ALLOC,
							index_t'($urandom_range(INDEX_MAX)));
				end
			end else if (episode == 8) begin
				repeat (20) begin
					send_request(bmalloc_pkg::OP_RELEASE,
						index_t'($urandom_range(INDEX_MAX / 2 + 1, INDEX_MAX)));
					send_request(bmalloc_pkg::OP_ALLOC,
						index_t'($urandom_range(INDEX_MAX)));
				end
			end else begin
				run_len = $urandom_range(20, 40);
				repeat (run_len)
					send_request(op_code_t'($urandom_range(3)),
						index_t'($urandom_range(INDEX_MAX)));
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (2 * bmalloc_pkg::ALLOC_WORDS + 8) @(posedge clk);

		if (failures == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
